>>> design/canfrx_pkg.sv
// ----------------------------------------------------------------------------
// canfrx_pkg
// Shared constants, codes and types of the CAN frame receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package canfrx_pkg;

   localparam int DEPTH   = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int LVL_W   = $clog2(DEPTH + 1);
   localparam int ID_W    = 29;
   localparam int DLC_W   = 4;
   localparam int DATA_W  = 64;
   localparam int FRAME_W = DLC_W + ID_W + DATA_W;
   localparam int CNT_W   = 32;
   localparam int OUT_LVL_W = 5;

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic       push_ok;
      logic       pop_ok;
      logic       drop;
      status_type status;
   } event_type;

endpackage

`default_nettype wire

>>> design/can_frame_rx_fifo_with_stats_core.sv
// ----------------------------------------------------------------------------
// can_frame_rx_fifo_with_stats_core
// CAN frame receive FIFO with drop-newest overflow and running statistics.
// ----------------------------------------------------------------------------
// One transaction is taken in every clock cycle: busy is never raised. The
// result of a transaction appears in the cycle after it is taken, marked by
// rsp_valid for exactly one cycle, and the receiver cannot stall it. The
// rate is set by the single pointer/level update per cycle; the popped
// frame comes from the frame RAM's registered read port in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_rx_fifo_with_stats_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_func,
   input  wire logic [canfrx_pkg::ID_W-1:0]     req_frame_id,
   input  wire logic [canfrx_pkg::DLC_W-1:0]    req_frame_dlc,
   input  wire logic [canfrx_pkg::DATA_W-1:0]   req_frame_data,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [canfrx_pkg::ID_W-1:0]          rsp_out_id,
   output logic [canfrx_pkg::DLC_W-1:0]         rsp_out_dlc,
   output logic [canfrx_pkg::DATA_W-1:0]        rsp_out_data,
   output logic [canfrx_pkg::OUT_LVL_W-1:0]     rsp_fill_level,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full,
   output logic [canfrx_pkg::CNT_W-1:0]         rsp_push_total,
   output logic [canfrx_pkg::CNT_W-1:0]         rsp_pop_total,
   output logic [canfrx_pkg::CNT_W-1:0]         rsp_drop_total,
   output logic [canfrx_pkg::OUT_LVL_W-1:0]     rsp_peak_fill
);

   logic                              accept;
   canfrx_pkg::event_type             evt;
   logic [canfrx_pkg::ADDR_W-1:0]     wr_addr, rd_addr;
   logic [canfrx_pkg::LVL_W-1:0]      level, peak;
   logic [canfrx_pkg::FRAME_W-1:0]    rd_frame;
   logic                              valid_ff, pop_ok_ff;
   canfrx_pkg::status_type            status_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   canfrx_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (req_func),
      .evt     (evt),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .level   (level)
   );

   canfrx_ram #(
      .WIDTH (canfrx_pkg::FRAME_W),
      .DEPTH (canfrx_pkg::DEPTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (evt.push_ok),
      .wr_addr    (wr_addr),
      .wr_data    ({req_frame_dlc, req_frame_id, req_frame_data}),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_frame)
   );

   canfrx_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .level      (level),
      .push_total (rsp_push_total),
      .pop_total  (rsp_pop_total),
      .drop_total (rsp_drop_total),
      .peak       (peak)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         pop_ok_ff <= 1'b0;
         status_ff <= canfrx_pkg::STATUS_OK;
      end else begin
         valid_ff  <= accept;
         pop_ok_ff <= evt.pop_ok;
         status_ff <= evt.status;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_data   = pop_ok_ff ? rd_frame[canfrx_pkg::DATA_W-1:0] : '0;
   assign rsp_out_id     = pop_ok_ff ?
      rd_frame[canfrx_pkg::DATA_W +: canfrx_pkg::ID_W] : '0;
   assign rsp_out_dlc    = pop_ok_ff ?
      rd_frame[canfrx_pkg::DATA_W + canfrx_pkg::ID_W +: canfrx_pkg::DLC_W] : '0;
   assign rsp_fill_level = canfrx_pkg::OUT_LVL_W'(level);
   assign rsp_is_empty   = (level == '0);
   assign rsp_is_full    = (level == canfrx_pkg::LVL_W'(canfrx_pkg::DEPTH));
   assign rsp_peak_fill  = canfrx_pkg::OUT_LVL_W'(peak);

endmodule

`default_nettype wire

>>> design/canfrx_ram.sv
// ----------------------------------------------------------------------------
// canfrx_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module canfrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> design/canfrx_ctrl.sv
// ----------------------------------------------------------------------------
// canfrx_ctrl
// Pointer and fill level control: decodes the operation, classifies it
// against the current level and advances the pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module canfrx_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [1:0]                   func,
   output canfrx_pkg::event_type             evt,
   output logic [canfrx_pkg::ADDR_W-1:0]     wr_addr,
   output logic [canfrx_pkg::ADDR_W-1:0]     rd_addr,
   output logic [canfrx_pkg::LVL_W-1:0]      level
);

   localparam logic [canfrx_pkg::ADDR_W-1:0] LAST_SLOT =
      canfrx_pkg::ADDR_W'(canfrx_pkg::DEPTH - 1);
   localparam logic [canfrx_pkg::LVL_W-1:0] FULL_LVL =
      canfrx_pkg::LVL_W'(canfrx_pkg::DEPTH);

   logic [canfrx_pkg::ADDR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [canfrx_pkg::LVL_W-1:0]  level_ff, level_in;
   logic                          is_push, is_pop, full, empty;

   always_comb begin
      is_push = (func == canfrx_pkg::FUNC_PUSH);
      is_pop  = (func == canfrx_pkg::FUNC_POP);
      full    = (level_ff == FULL_LVL);
      empty   = (level_ff == '0);

      evt.push_ok = accept && is_push && !full;
      evt.drop    = accept && is_push && full;
      evt.pop_ok  = accept && is_pop && !empty;
      if (evt.drop) begin
         evt.status = canfrx_pkg::STATUS_FULL;
      end else if (is_pop && empty) begin
         evt.status = canfrx_pkg::STATUS_EMPTY;
      end else begin
         evt.status = canfrx_pkg::STATUS_OK;
      end

      wp_in    = wp_ff;
      rp_in    = rp_ff;
      level_in = level_ff;
      if (evt.push_ok) begin
         wp_in    = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
         level_in = level_ff + 1'b1;
      end
      if (evt.pop_ok) begin
         rp_in    = (rp_ff == LAST_SLOT) ? '0 : rp_ff + 1'b1;
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         level_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         level_ff <= level_in;
      end
   end

   assign wr_addr = wp_ff;
   assign rd_addr = rp_ff;
   assign level   = level_ff;

endmodule

`default_nettype wire

>>> design/canfrx_stats.sv
// ----------------------------------------------------------------------------
// canfrx_stats
// Saturating push, pop and drop counters and the peak fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module canfrx_stats (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire canfrx_pkg::event_type       evt,
   input  wire logic [canfrx_pkg::LVL_W-1:0] level,
   output logic [canfrx_pkg::CNT_W-1:0]     push_total,
   output logic [canfrx_pkg::CNT_W-1:0]     pop_total,
   output logic [canfrx_pkg::CNT_W-1:0]     drop_total,
   output logic [canfrx_pkg::LVL_W-1:0]     peak
);

   logic [canfrx_pkg::CNT_W-1:0] push_ff, push_in, pop_ff, pop_in, drop_ff, drop_in;
   logic [canfrx_pkg::LVL_W-1:0] peak_ff, peak_in, level_after;

   always_comb begin
      push_in = push_ff;
      pop_in  = pop_ff;
      drop_in = drop_ff;
      peak_in = peak_ff;
      level_after = level + 1'b1;
      if (evt.push_ok && (push_ff != '1)) begin
         push_in = push_ff + 1'b1;
      end
      if (evt.pop_ok && (pop_ff != '1)) begin
         pop_in = pop_ff + 1'b1;
      end
      if (evt.drop && (drop_ff != '1)) begin
         drop_in = drop_ff + 1'b1;
      end
      if (evt.push_ok && (level_after > peak_ff)) begin
         peak_in = level_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         push_ff <= '0;
         pop_ff  <= '0;
         drop_ff <= '0;
         peak_ff <= '0;
      end else begin
         push_ff <= push_in;
         pop_ff  <= pop_in;
         drop_ff <= drop_in;
         peak_ff <= peak_in;
      end
   end

   assign push_total = push_ff;
   assign pop_total  = pop_ff;
   assign drop_total = drop_ff;
   assign peak       = peak_ff;

endmodule

`default_nettype wire
